### rtl/core/drcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcc_pkg
// Shared types and constants for the delta-R cross cleaner.
// ----------------------------------------------------------------------------
package drcc_pkg;

  localparam int unsigned MaxRefs = 16;
  localparam int unsigned IdxW    = $clog2(MaxRefs);
  localparam int unsigned CntW    = $clog2(MaxRefs + 1);

  localparam int unsigned EtaW  = 13;
  localparam int unsigned PhiW  = 12;
  localparam int unsigned Dr2W  = 25;
  localparam int unsigned Eta2W = 27;  // (2^13 - 1)^2 fits
  localparam int unsigned Phi2W = 23;  // 2048^2 fits
  localparam int unsigned SumW  = 28;

  localparam logic [Dr2W-1:0] Dr2Reset = Dr2W'(1061);

  localparam logic CmdRef   = 1'b0;
  localparam logic CmdOther = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } drcc_state_e;

  typedef struct packed {
    logic accept;    // latch request, update store
    logic issue;     // read next reference into compare pipe
    logic load_out;  // move result into output register
  } drcc_cmd_t;

  typedef struct packed {
    logic in_is_ref;  // command field of the waiting request
    logic scan_done;  // all stored references issued
    logic pipe_busy;  // compares still in flight
    logic out_free;   // output register can take a result
  } drcc_status_t;

endpackage

### rtl/core/drcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcc_ctrl
// Controller: sequences accept, reference scan, drain and result load.
// ----------------------------------------------------------------------------
module drcc_ctrl import drcc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  drcc_status_t status_i,
  output drcc_cmd_t    cmd_o
);

  drcc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_is_ref ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.issue = !status_i.scan_done;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/core/drcc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drcc_dp
// Datapath: reference store, scan index, distance pipe, threshold, result.
// ----------------------------------------------------------------------------
module drcc_dp import drcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  drcc_cmd_t              cmd_i,
  output drcc_status_t           status_o,
  input  logic                   command_i,
  input  logic                   start_of_event_i,
  input  logic signed [EtaW-1:0] eta_i,
  input  logic        [PhiW-1:0] phi_i,
  input  logic                   cfg_we_i,
  input  logic        [Dr2W-1:0] cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   keep_o,
  output logic                   reference_dropped_o
);

  logic [EtaW-1:0] eta_mem [MaxRefs];
  logic [PhiW-1:0] phi_mem [MaxRefs];

  logic [Dr2W-1:0] thr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q;
  logic            cmd_q;
  logic signed [EtaW-1:0] eta_q;
  logic        [PhiW-1:0] phi_q;
  logic            dropped_q, dropped_d;
  logic            match_q;

  logic            v1_q, v2_q;
  logic signed [EtaW-1:0] rd_eta_q;
  logic        [PhiW-1:0] rd_phi_q;
  logic [Eta2W-1:0] e2_q;
  logic [Phi2W-1:0] p2_q;

  logic            out_valid_q, keep_q, out_drop_q;

  logic [CntW-1:0] eff_count;
  logic            has_room;
  logic            do_store;

  logic signed [EtaW:0]     de;
  logic signed [PhiW-1:0]   dp;
  logic signed [2*EtaW+1:0] de_sq;
  logic signed [2*PhiW-1:0] dp_sq;
  logic [SumW-1:0]          dist_sum;

  // start of event empties the store before the request is handled
  assign eff_count = start_of_event_i ? '0 : count_q;
  assign has_room  = (eff_count < CntW'(MaxRefs));
  assign do_store  = cmd_i.accept && (command_i == CmdRef) && has_room;

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.accept) begin
      count_d   = do_store ? eff_count + CntW'(1) : eff_count;
      dropped_d = (command_i == CmdRef) && !has_room;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) begin
      eta_mem[eff_count[IdxW-1:0]] <= eta_i;
      phi_mem[eff_count[IdxW-1:0]] <= phi_i;
    end
    if (cmd_i.issue) begin
      rd_eta_q <= eta_mem[idx_q[IdxW-1:0]];
      rd_phi_q <= phi_mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= Dr2Reset;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  // request latch and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q     <= command_i;
      eta_q     <= eta_i;
      phi_q     <= phi_i;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.issue) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  // distance pipe: read -> squares -> sum and compare
  assign de       = (EtaW+1)'(eta_q) - (EtaW+1)'(rd_eta_q);
  assign dp       = $signed(phi_q - rd_phi_q);  // wraps modulo a full turn
  assign de_sq    = de * de;
  assign dp_sq    = dp * dp;
  assign dist_sum = SumW'(e2_q) + SumW'(p2_q);

  always_ff @(posedge clk_i) begin
    e2_q <= de_sq[Eta2W-1:0];
    p2_q <= dp_sq[Phi2W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.accept) begin
        match_q <= 1'b0;
      end else if (v2_q && (dist_sum <= SumW'(thr_q))) begin
        match_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      keep_q     <= (cmd_q == CmdRef) || !match_q;
      out_drop_q <= (cmd_q == CmdRef) && dropped_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign keep_o              = keep_q;
  assign reference_dropped_o = out_drop_q;

  assign status_o.in_is_ref = (command_i == CmdRef);
  assign status_o.scan_done = (idx_q == count_q);
  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### rtl/core/delta_r_cross_cleaner.sv
`timescale 1ns / 1ps
// Sequence: a reference request goes from accept to the finish state, where the
//   result loads once the output register is free; an other request first scans
//   the N stored references (0..16) through the distance compare pipe, one entry
//   per cycle, and drains it first. A new request is taken only in the idle state.
// Reset: async active low; store count cleared, threshold back to 1061,
//   store contents left undefined.
// ----------------------------------------------------------------------------
// delta_r_cross_cleaner
// Top level: removes other objects within delta-R of stored reference objects.
// ----------------------------------------------------------------------------
module delta_r_cross_cleaner import drcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic                   start_of_event_i,
  input  logic signed [EtaW-1:0] eta_i,
  input  logic        [PhiW-1:0] phi_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   keep_o,
  output logic                   reference_dropped_o,
  input  logic                   cfg_we_i,
  input  logic        [Dr2W-1:0] cfg_wdata_i
);

  drcc_cmd_t    cmd;
  drcc_status_t status;

  drcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  drcc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_i           (command_i),
    .start_of_event_i    (start_of_event_i),
    .eta_i               (eta_i),
    .phi_i               (phi_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .keep_o              (keep_o),
    .reference_dropped_o (reference_dropped_o)
  );

endmodule

### bench/tb_delta_r_cross_cleaner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_r_cross_cleaner
// Self-checking bench: drives reference and other requests through the
// valid/stall channels while the receiver stalls. A local model of the
// reference store predicts keep and reference_dropped for every request, and
// results are checked in order. Covers matches at the threshold, phi wrap,
// store overflow, start-of-event clearing, several thresholds and long stalls.
// ----------------------------------------------------------------------------
module tb_delta_r_cross_cleaner;
  import drcc_pkg::*;

  localparam int unsigned HoldCycles    = 300;   // long receiver hold-off
  localparam int unsigned SettleCycles  = 24;    // idle time after the last result
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [Dr2W-1:0] Dr2Max    = '1;

  typedef struct packed {
    logic keep;
    logic dropped;
  } clean_verdict_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   command = CmdRef;
  logic                   start_of_event = 1'b0;
  logic signed [EtaW-1:0] eta = '0;
  logic        [PhiW-1:0] phi = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   keep;
  logic                   reference_dropped;
  logic                   cfg_we = 1'b0;
  logic        [Dr2W-1:0] cfg_wdata = '0;

  // Predictor state: mirror of the reference store and the threshold
  logic signed [EtaW-1:0] ref_eta [MaxRefs];
  logic        [PhiW-1:0] ref_phi [MaxRefs];
  int unsigned            stored_refs = 0;
  logic        [Dr2W-1:0] dr2_limit = Dr2Reset;

  clean_verdict_t pending_verdicts[$];
  int unsigned    fail_count = 0;
  int unsigned    burst_left = 0;
  logic           no_gaps = 1'b0;
  logic           hold_trigger = 1'b0;

  delta_r_cross_cleaner u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .command_i           (command),
    .start_of_event_i    (start_of_event),
    .eta_i               (eta),
    .phi_i               (phi),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .keep_o              (keep),
    .reference_dropped_o (reference_dropped),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic clean_verdict_t predict_clean_result(
    input logic                   cmd,
    input logic                   sof,
    input logic signed [EtaW-1:0] req_eta,
    input logic        [PhiW-1:0] req_phi
  );
    clean_verdict_t         v;
    logic signed [EtaW:0]   d_eta;
    logic        [PhiW-1:0] d_phi;
    longint                 dist2;
    v.keep    = 1'b1;
    v.dropped = 1'b0;
    if (sof) stored_refs = 0;
    if (cmd == CmdRef) begin
      if (stored_refs < MaxRefs) begin
        ref_eta[stored_refs] = req_eta;
        ref_phi[stored_refs] = req_phi;
        stored_refs++;
      end else begin
        v.dropped = 1'b1;
      end
    end else begin
      for (int i = 0; i < stored_refs; i++) begin
        d_eta = req_eta - ref_eta[i];
        d_phi = req_phi - ref_phi[i];  // wraps modulo one turn
        dist2 = longint'(d_eta) * longint'(d_eta)
              + longint'($signed(d_phi)) * longint'($signed(d_phi));
        if (dist2 <= longint'(dr2_limit)) v.keep = 1'b0;
      end
    end
    return v;
  endfunction

  // Send one request; valid stays high across back-to-back requests
  task automatic send_request(
    input logic                   cmd,
    input logic                   sof,
    input logic signed [EtaW-1:0] req_eta,
    input logic        [PhiW-1:0] req_phi
  );
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid       <= 1'b1;
    command        <= cmd;
    start_of_event <= sof;
    eta            <= req_eta;
    phi            <= req_phi;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_verdicts = {pending_verdicts, predict_clean_result(cmd, sof, req_eta, req_phi)};
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [Dr2W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    dr2_limit = value;
  endtask

  function automatic logic signed [EtaW-1:0] rand_eta();
    return EtaW'($urandom);
  endfunction

  function automatic logic [PhiW-1:0] rand_phi();
    return PhiW'($urandom);
  endfunction

  // Default threshold: boundary distances, phi wrap, field extremes, start flag
  task automatic test_default_matches();
    send_request(CmdRef,   1'b1, 13'sd0, 12'd0);
    send_request(CmdOther, 1'b0, 13'sd0, 12'd0);      // same point
    send_request(CmdOther, 1'b0, 13'sd32, 12'd5);     // 1049, removed
    send_request(CmdOther, 1'b0, 13'sd33, 12'd0);     // 1089, kept
    send_request(CmdOther, 1'b0, -13'sd4, 12'd4064);  // phi wraps below zero
    send_request(CmdRef,   1'b0, -13'sd4096, 12'd4095);
    send_request(CmdOther, 1'b0, -13'sd4096, 12'd0);  // wraps above the turn
    send_request(CmdOther, 1'b0, 13'sd4095, 12'd2048);
    send_request(CmdOther, 1'b1, 13'sd0, 12'd0);      // store emptied first
    send_request(CmdOther, 1'b0, 13'sd0, 12'd0);
  endtask

  // Fill the store, overflow it, check that dropped references never match
  task automatic test_store_full();
    for (int i = 0; i < MaxRefs; i++)
      send_request(CmdRef, i == 0, EtaW'(i * 200 - 1600), PhiW'(i * 256));
    send_request(CmdRef,   1'b0, 13'sd3000, 12'd100);  // dropped
    send_request(CmdRef,   1'b0, 13'sd3000, 12'd100);  // dropped again
    send_request(CmdOther, 1'b0, 13'sd3000, 12'd100);  // kept
    send_request(CmdOther, 1'b0, 13'sd1400, 12'd3840); // hits the last stored
    send_request(CmdRef,   1'b1, 13'sd3000, 12'd100);  // new event stores it
    send_request(CmdOther, 1'b0, 13'sd3000, 12'd100);
  endtask

  task automatic test_threshold_extremes();
    set_threshold('0);
    send_request(CmdRef,   1'b1, 13'sd100, 12'd100);
    send_request(CmdOther, 1'b0, 13'sd101, 12'd100);
    send_request(CmdOther, 1'b0, 13'sd100, 12'd100);
    set_threshold(Dr2Max);
    send_request(CmdRef,   1'b1, 13'sd0, 12'd0);
    send_request(CmdOther, 1'b0, 13'sd4095, 12'd2048);  // 20.9e6, removed
    send_request(CmdRef,   1'b1, 13'sd4095, 12'd0);
    send_request(CmdOther, 1'b0, -13'sd4096, 12'd2048); // 71e6, kept
  endtask

  // Well-formed events with random content, plus noise and broken events
  task automatic run_events(input int unsigned n_items);
    int unsigned            sent;
    int unsigned            n_ref;
    int unsigned            n_other;
    int unsigned            span;
    int unsigned            k;
    logic signed [EtaW-1:0] ev_eta[$];
    logic        [PhiW-1:0] ev_phi[$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0,
                     rand_eta(), rand_phi());
        sent++;
      end else begin
        n_ref   = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
        n_other = $urandom_range(1, 10);
        ev_eta.delete();
        ev_phi.delete();
        for (int i = 0; i < n_ref; i++) begin
          ev_eta = {ev_eta, rand_eta()};
          ev_phi = {ev_phi, rand_phi()};
          send_request(CmdRef, i == 0, ev_eta[i], ev_phi[i]);
        end
        for (int i = 0; i < n_other; i++) begin
          // a broken event: no start flag at all, left to the previous store
          if (ev_eta.size() != 0 && $urandom_range(0, 3) != 0) begin
            k    = $urandom_range(0, ev_eta.size() - 1);
            span = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 40);
            send_request(CmdOther, 1'b0,
                         EtaW'(int'(ev_eta[k]) + int'($urandom_range(0, 2 * span)) - int'(span)),
                         PhiW'(int'(ev_phi[k]) + int'($urandom_range(0, 2 * span)) - int'(span)));
          end else begin
            send_request(CmdOther, n_ref == 0 && i == 0 && $urandom_range(0, 1) == 0,
                         rand_eta(), rand_phi());
          end
        end
        sent += n_ref + n_other;
      end
    end
  endtask

  // Receiver holds off while requests keep coming, then the sender drains
  task automatic test_backpressure();
    no_gaps      = 1'b1;
    hold_trigger <= ~hold_trigger;
    run_events(60);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_default_matches();
    test_store_full();
    run_events(700);
    test_threshold_extremes();
    run_events(200);
    set_threshold('0);
    run_events(200);
    set_threshold(Dr2W'($urandom_range(1062, 200000)));
    run_events(300);
    set_threshold(Dr2Reset);
    run_events(100);
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver stall pattern, with an occasional long hold-off on request
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_phase = 0;
  logic        hold_seen = 1'b0;

  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_phase % 5) < 2;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    clean_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no request pending: keep %0d, reference_dropped %0d",
               keep, reference_dropped);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (keep !== want.keep) begin
          $error("keep: expected %0d, actual %0d", want.keep, keep);
          fail_count++;
        end
        if (reference_dropped !== want.dropped) begin
          $error("reference_dropped: expected %0d, actual %0d",
                 want.dropped, reference_dropped);
          fail_count++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
